### rtl/rcp_pkg.sv
// rcp_pkg: command record, character codes and reply table for the relay command parser
`timescale 1ns / 1ps
`default_nettype none

package rcp_pkg;

   localparam int unsigned BYTE_WIDTH        = 8;
   localparam int unsigned POSITION_WIDTH    = 9;
   localparam int unsigned SEEN_WIDTH        = 3;
   localparam int unsigned LETTER_COUNT      = 4;
   localparam int unsigned RELAY_INDEX_WIDTH = 4;   // covers relay numbers up to nine
   localparam int unsigned RELAY_OUT_WIDTH   = 6;
   localparam int unsigned BEAT_WIDTH        = 3;

   localparam logic [POSITION_WIDTH-1:0] POSITION_TOP = 9'd511;
   localparam logic [BEAT_WIDTH-1:0]     BEAT_LAST    = 3'd5;

   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'd48;   // '0'
   localparam logic [BYTE_WIDTH-1:0] CHAR_ONE   = 8'd49;   // '1'
   localparam logic [BYTE_WIDTH-1:0] CHAR_G     = 8'h47;
   localparam logic [BYTE_WIDTH-1:0] CHAR_O     = 8'h4F;
   localparam logic [BYTE_WIDTH-1:0] CHAR_S     = 8'h53;
   localparam logic [BYTE_WIDTH-1:0] CHAR_T     = 8'h54;
   localparam logic [BYTE_WIDTH-1:0] CHAR_U     = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] CHAR_V     = 8'h56;
   localparam logic [BYTE_WIDTH-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_WIDTH-1:0] NO_REPLY   = 8'h00;

   typedef enum logic [1:0] {
      CMD_NONE       = 2'd0,
      CMD_GO         = 2'd1,
      CMD_SET_RELAY  = 2'd2,
      CMD_SET_SUPERV = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic [RELAY_INDEX_WIDTH-1:0] relay_index;   // relay number minus one
      logic                         value;         // new relay bit or supervision flag
   } cmd_type;

   // reply text "OUTn:s", one character per beat
   function automatic logic [BYTE_WIDTH-1:0] reply_char(
      input logic [BEAT_WIDTH-1:0]        beat,
      input logic [RELAY_INDEX_WIDTH-1:0] relay_index,
      input logic                         relay_on
   );
      logic [BYTE_WIDTH-1:0] ch;
      unique case (beat)
         3'd0:    ch = CHAR_O;
         3'd1:    ch = CHAR_U;
         3'd2:    ch = CHAR_T;
         3'd3:    ch = CHAR_ONE + BYTE_WIDTH'(relay_index);
         3'd4:    ch = CHAR_COLON;
         3'd5:    ch = relay_on ? CHAR_ONE : CHAR_ZERO;
         default: ch = NO_REPLY;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/rcp_front.sv
// rcp_front: byte intake, command letter capture and command classification
`timescale 1ns / 1ps
`default_nettype none

module rcp_front #(
   parameter int RELAY_COUNT = 6
) (
   input  wire  logic                           clock,
   input  wire  logic                           reset,
   input  wire  logic                           csr_write_enable,
   input  wire  logic [rcp_pkg::BYTE_WIDTH-1:0] csr_write_data,
   input  wire  logic                           req_valid,
   output logic                                 req_stall,
   input  wire  logic [rcp_pkg::BYTE_WIDTH-1:0] req_message_byte,
   input  wire  logic                           req_message_end,
   input  wire  logic                           queue_full,
   output logic                                 cmd_push,
   output rcp_pkg::cmd_type                     cmd
);
   import rcp_pkg::*;

   logic [BYTE_WIDTH-1:0]     offset_ff, offset_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic [SEEN_WIDTH-1:0]     seen_ff, seen_in;
   logic [BYTE_WIDTH-1:0]     letters_ff [LETTER_COUNT];
   logic [BYTE_WIDTH-1:0]     letters_in [LETTER_COUNT];

   logic                      accept;
   logic                      take;
   logic [POSITION_WIDTH-1:0] capture_position;
   logic [SEEN_WIDTH-1:0]     seen_upd;
   logic [BYTE_WIDTH-1:0]     digit_off;
   logic                      digit_ok;
   logic [BYTE_WIDTH-1:0]     value_off;

   // only a closing byte needs room in the command queue
   assign req_stall = queue_full && req_message_end;
   assign accept    = req_valid && !req_stall;

   assign capture_position = {1'b0, offset_ff} + POSITION_WIDTH'(seen_ff);
   assign take = accept && (seen_ff < SEEN_WIDTH'(LETTER_COUNT))
                 && (position_ff == capture_position);
   assign seen_upd = take ? seen_ff + 1'b1 : seen_ff;

   always_comb begin
      letters_in = letters_ff;
      if (take) begin
         letters_in[seen_ff[1:0]] = req_message_byte;
      end
   end

   always_comb begin
      offset_in = csr_write_enable ? csr_write_data : offset_ff;
      position_in = position_ff;
      seen_in     = seen_ff;
      if (accept) begin
         if (req_message_end) begin
            position_in = '0;
            seen_in     = '0;
         end else begin
            position_in = (position_ff != POSITION_TOP) ? position_ff + 1'b1 : position_ff;
            seen_in     = seen_upd;
         end
      end
   end

   // classification sees the letters including one taken on the closing byte
   assign digit_off = letters_in[2] - CHAR_ZERO;
   assign digit_ok  = (digit_off != '0) && (digit_off <= BYTE_WIDTH'(RELAY_COUNT));
   assign value_off = letters_in[3] - CHAR_ZERO;

   always_comb begin
      cmd.kind        = CMD_NONE;
      cmd.relay_index = RELAY_INDEX_WIDTH'(digit_off - 8'd1);
      cmd.value       = 1'b0;
      priority if (seen_upd >= 3'd3 && letters_in[0] == CHAR_G
                   && letters_in[1] == CHAR_O && digit_ok) begin
         cmd.kind = CMD_GO;
      end else if (seen_upd >= 3'd4 && letters_in[0] == CHAR_S) begin
         priority if (letters_in[1] == CHAR_O && digit_ok) begin
            if (value_off < 8'd2) begin
               cmd.kind  = CMD_SET_RELAY;
               cmd.value = value_off[0];
            end
         end else if (letters_in[1] == CHAR_S && letters_in[2] == CHAR_V) begin
            cmd.kind  = CMD_SET_SUPERV;
            cmd.value = (value_off != '0);
         end else begin
            cmd.kind = CMD_NONE;
         end
      end else begin
         cmd.kind = CMD_NONE;
      end
   end

   assign cmd_push = accept && req_message_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         position_ff <= '0;
         seen_ff     <= '0;
      end else begin
         offset_ff   <= offset_in;
         position_ff <= position_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      letters_ff <= letters_in;
   end

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_WIDTH'(LETTER_COUNT))
      else $error("letter count beyond four");

endmodule

`default_nettype wire

### rtl/rcp_queue.sv
// rcp_queue: two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module rcp_queue (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       push,
   input  wire  rcp_pkg::cmd_type push_cmd,
   input  wire  logic       pop,
   output rcp_pkg::cmd_type head_cmd,
   output logic             empty,
   output logic             full
);
   import rcp_pkg::*;

   localparam int Depth = 2;
   localparam int PtrWidth = $clog2(Depth);

   cmd_type                entries_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]      count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (PtrWidth + 1)'(Depth));
   assign head_cmd = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrWidth + 1)'(Depth))
      else $error("queue count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command pushed into full queue");

endmodule

`default_nettype wire

### rtl/rcp_back.sv
// rcp_back: command execution, relay and supervision state, result register
`timescale 1ns / 1ps
`default_nettype none

module rcp_back #(
   parameter int RELAY_COUNT = 6
) (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  rcp_pkg::cmd_type                    head_cmd,
   input  wire  logic                                queue_empty,
   output logic                                      queue_pop,
   output logic                                      rsp_valid,
   input  wire  logic                                rsp_stall,
   output logic [rcp_pkg::BYTE_WIDTH-1:0]            rsp_reply_byte,
   output logic                                      rsp_has_reply,
   output logic                                      rsp_reply_last,
   output logic [rcp_pkg::RELAY_OUT_WIDTH-1:0]       rsp_relay_states,
   output logic                                      rsp_supervision_on
);
   import rcp_pkg::*;

   localparam int RelayWidth = (RELAY_COUNT > RELAY_OUT_WIDTH) ? RELAY_COUNT : RELAY_OUT_WIDTH;

   logic [RelayWidth-1:0]      relay_ff, relay_in;
   logic                       superv_ff, superv_in;
   logic [BEAT_WIDTH-1:0]      beat_ff, beat_in;
   logic                       valid_ff, valid_in;
   logic [BYTE_WIDTH-1:0]      byte_ff, byte_in;
   logic                       has_ff, has_in;
   logic                       last_ff, last_in;
   logic [RELAY_OUT_WIDTH-1:0] states_ff, states_in;
   logic                       superv_out_ff, superv_out_in;

   logic                       out_free;
   logic                       fire;
   logic                       is_go;
   logic                       relay_on;

   assign out_free = !valid_ff || !rsp_stall;
   assign fire     = out_free && !queue_empty;
   assign is_go    = (head_cmd.kind == CMD_GO);
   assign queue_pop = fire && (!is_go || beat_ff == BEAT_LAST);

   always_comb begin
      relay_on = 1'b0;
      for (int k = 0; k < RelayWidth; k++) begin
         if (RELAY_INDEX_WIDTH'(k) == head_cmd.relay_index) begin
            relay_on = relay_ff[k];
         end
      end
   end

   always_comb begin
      relay_in  = relay_ff;
      superv_in = superv_ff;
      if (fire) begin
         unique case (head_cmd.kind)
            CMD_SET_RELAY: begin
               for (int k = 0; k < RelayWidth; k++) begin
                  if (RELAY_INDEX_WIDTH'(k) == head_cmd.relay_index) begin
                     relay_in[k] = head_cmd.value;
                  end
               end
            end
            CMD_SET_SUPERV: superv_in = head_cmd.value;
            CMD_GO, CMD_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      beat_in = beat_ff;
      if (fire) begin
         beat_in = (is_go && beat_ff != BEAT_LAST) ? beat_ff + 1'b1 : '0;
      end
      valid_in = out_free ? fire : valid_ff;
      byte_in  = is_go ? reply_char(beat_ff, head_cmd.relay_index, relay_on) : NO_REPLY;
      has_in   = is_go;
      last_in  = !is_go || (beat_ff == BEAT_LAST);
      states_in     = relay_in[RELAY_OUT_WIDTH-1:0];
      superv_out_in = superv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff  <= '0;
         superv_ff <= 1'b0;
         beat_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         relay_ff  <= relay_in;
         superv_ff <= superv_in;
         beat_ff   <= beat_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff       <= byte_in;
         has_ff        <= has_in;
         last_ff       <= last_in;
         states_ff     <= states_in;
         superv_out_ff <= superv_out_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_reply_byte     = byte_ff;
   assign rsp_has_reply      = has_ff;
   assign rsp_reply_last     = last_ff;
   assign rsp_relay_states   = states_ff;
   assign rsp_supervision_on = superv_out_ff;

   a_beat_only_in_go: assert property (@(posedge clock) disable iff (reset)
      beat_ff != '0 |-> !queue_empty && is_go)
      else $error("reply beat running without a go command at the head");

   a_no_reply_is_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !has_ff |-> byte_ff == NO_REPLY && last_ff)
      else $error("result without reply carries a byte or is not last");

endmodule

`default_nettype wire

### rtl/relay_command_parser.sv
// relay_command_parser: top level joining intake, command queue and execution
//
//   channel | ports                                          | role
//   --------+------------------------------------------------+---------------------
//   req     | req_valid, req_stall, req_message_byte/_end    | message bytes in
//   rsp     | rsp_valid, rsp_stall, rsp_reply_byte, ...      | result items out
//   csr     | csr_write_enable, csr_write_data               | command offset write
//
// one item accepted per cycle; a closing byte waits only while the command queue is full
// the back emits one result per cycle when not stalled: six for go, one for others
// a message's command is registered in the command queue, then in the result register
// reset is synchronous and clears offset, position, letter count, relays and flag
// a stalled result holds in the output register while the front keeps taking bytes
`timescale 1ns / 1ps
`default_nettype none

module relay_command_parser #(
   parameter int RELAY_COUNT = 6
) (
   input  wire  logic                                 clock,
   input  wire  logic                                 reset,
   // configuration
   input  wire  logic                                 csr_write_enable,
   input  wire  logic [rcp_pkg::BYTE_WIDTH-1:0]       csr_write_data,
   // message bytes
   input  wire  logic                                 req_valid,
   output logic                                       req_stall,
   input  wire  logic [rcp_pkg::BYTE_WIDTH-1:0]       req_message_byte,
   input  wire  logic                                 req_message_end,
   // result items
   output logic                                       rsp_valid,
   input  wire  logic                                 rsp_stall,
   output logic [rcp_pkg::BYTE_WIDTH-1:0]             rsp_reply_byte,
   output logic                                       rsp_has_reply,
   output logic                                       rsp_reply_last,
   output logic [rcp_pkg::RELAY_OUT_WIDTH-1:0]        rsp_relay_states,
   output logic                                       rsp_supervision_on
);
   import rcp_pkg::*;

   // classified command handed from front to back
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    cmd_push;
   logic    queue_pop;
   logic    queue_empty;
   logic    queue_full;

   // intake: offset register, byte position, letter capture, classification
   rcp_front #(
      .RELAY_COUNT (RELAY_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_byte (req_message_byte),
      .req_message_end  (req_message_end),
      .queue_full       (queue_full),
      .cmd_push         (cmd_push),
      .cmd              (push_cmd)
   );

   // short queue so the front keeps taking bytes while replies drain
   rcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (queue_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // execution: relay and supervision state, reply sequencing, output register
   rcp_back #(
      .RELAY_COUNT (RELAY_COUNT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_cmd           (head_cmd),
      .queue_empty        (queue_empty),
      .queue_pop          (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_reply_byte     (rsp_reply_byte),
      .rsp_has_reply      (rsp_has_reply),
      .rsp_reply_last     (rsp_reply_last),
      .rsp_relay_states   (rsp_relay_states),
      .rsp_supervision_on (rsp_supervision_on)
   );

endmodule

`default_nettype wire
